>>> hw/rtl/fpd_pkg.sv
// shared types and constants of the flight phase detector
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

    localparam int ALTITUDE_BITS = 24;
    localparam int ACCEL_BITS    = 16;
    localparam int TIME_BITS     = 32;

    localparam int RISE_BITS   = 17;
    localparam int EXCESS_BITS = 14;
    localparam int DROP_BITS   = 17;
    localparam int BAND_BITS   = 17;
    localparam int HOLD_BITS   = 20;

    localparam int ONE_G_MG  = 1000;
    localparam int LIM_BITS  = EXCESS_BITS + 1;
    localparam int LSQ_BITS  = 2 * LIM_BITS;
    localparam int SQ_BITS   = 2 * ACCEL_BITS;
    localparam int MAG_BITS  = SQ_BITS + 2;
    localparam int DIFF_BITS = ALTITUDE_BITS + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = PTR_BITS + 1;
    localparam int OCC_BITS    = CNT_BITS + 1;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [RISE_BITS-1:0]   RISE_RESET   = RISE_BITS'(1000);
    localparam logic [EXCESS_BITS-1:0] EXCESS_RESET = EXCESS_BITS'(500);
    localparam logic [DROP_BITS-1:0]   DROP_RESET   = DROP_BITS'(100);
    localparam logic [BAND_BITS-1:0]   BAND_RESET   = BAND_BITS'(200);
    localparam logic [HOLD_BITS-1:0]   HOLD_RESET   = HOLD_BITS'(3000);

    typedef enum logic [2:0] {
        REG_LAUNCH_RISE  = 3'd0,
        REG_ACCEL_EXCESS = 3'd1,
        REG_DESCENT_DROP = 3'd2,
        REG_STABLE_BAND  = 3'd3,
        REG_LANDING_HOLD = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_PRE  = 2'd0,
        PH_ASC  = 2'd1,
        PH_DES  = 2'd2,
        PH_LAND = 2'd3
    } phase_t;

    typedef struct packed {
        logic [RISE_BITS-1:0]   launch_rise_cm;
        logic [EXCESS_BITS-1:0] accel_excess_mg;
        logic [DROP_BITS-1:0]   descent_drop_cm;
        logic [BAND_BITS-1:0]   stable_band_cm;
        logic [HOLD_BITS-1:0]   landing_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [ALTITUDE_BITS-1:0] altitude_cm;
        logic signed [ACCEL_BITS-1:0]    accel_x_mg;
        logic signed [ACCEL_BITS-1:0]    accel_y_mg;
        logic signed [ACCEL_BITS-1:0]    accel_z_mg;
        logic [TIME_BITS-1:0]            time_ms;
    } sample_t;

    typedef struct packed {
        logic [1:0] flight_state;
        logic       state_changed;
        logic       landing_event;
    } result_t;

    typedef struct packed {
        logic signed [ALTITUDE_BITS-1:0] altitude_cm;
        logic [TIME_BITS-1:0]            time_ms;
        logic                            accel_launch;
    } queue_word_t;

    typedef struct packed {
        logic                valid;
        logic [CNT_BITS-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fpd_front.sv
// front end: takes samples and classifies acceleration magnitude against the launch limit
`timescale 1ns / 1ps
`default_nettype none

module fpd_front
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fpd_pkg::cfg_t         cfg,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire fpd_pkg::sample_t      sample,
    input  wire fpd_pkg::queue_status_t qstat,
    output logic                       push,
    output fpd_pkg::queue_word_t       push_word
);
    import fpd_pkg::*;

    logic                          accept;
    logic                          s1_valid_reg;
    logic signed [ALTITUDE_BITS-1:0] s1_alt_reg;
    logic [TIME_BITS-1:0]          s1_time_reg;
    logic [SQ_BITS-1:0]            sq_x_reg;
    logic [SQ_BITS-1:0]            sq_y_reg;
    logic [SQ_BITS-1:0]            sq_z_reg;
    logic [LSQ_BITS-1:0]           lim_sq_reg;
    logic                          s2_valid_reg;
    queue_word_t                   s2_word_reg;
    logic signed [SQ_BITS-1:0]     prod_x;
    logic signed [SQ_BITS-1:0]     prod_y;
    logic signed [SQ_BITS-1:0]     prod_z;
    logic [LIM_BITS-1:0]           lim;
    logic [MAG_BITS-1:0]           mag_sq;
    logic [OCC_BITS-1:0]           occupancy;

    // words in flight plus words queued must fit the queue
    assign occupancy = OCC_BITS'(qstat.count) + OCC_BITS'(s1_valid_reg)
                     + OCC_BITS'(s2_valid_reg);
    assign sample_stall = (occupancy >= OCC_BITS'(QUEUE_DEPTH));
    assign accept = sample_valid && !sample_stall;

    assign prod_x = sample.accel_x_mg * sample.accel_x_mg;
    assign prod_y = sample.accel_y_mg * sample.accel_y_mg;
    assign prod_z = sample.accel_z_mg * sample.accel_z_mg;
    assign lim    = LIM_BITS'(ONE_G_MG) + LIM_BITS'(cfg.accel_excess_mg);
    assign mag_sq = MAG_BITS'(sq_x_reg) + MAG_BITS'(sq_y_reg) + MAG_BITS'(sq_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_alt_reg  <= sample.altitude_cm;
        s1_time_reg <= sample.time_ms;
        sq_x_reg    <= SQ_BITS'(unsigned'(prod_x));
        sq_y_reg    <= SQ_BITS'(unsigned'(prod_y));
        sq_z_reg    <= SQ_BITS'(unsigned'(prod_z));
        lim_sq_reg  <= lim * lim;
        s2_word_reg.altitude_cm  <= s1_alt_reg;
        s2_word_reg.time_ms      <= s1_time_reg;
        s2_word_reg.accel_launch <= (mag_sq > MAG_BITS'(lim_sq_reg));
    end

    assign push      = s2_valid_reg;
    assign push_word = s2_word_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fpd_queue.sv
// short queue between the front end and the phase tracker
`timescale 1ns / 1ps
`default_nettype none

module fpd_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire fpd_pkg::queue_word_t   push_word,
    input  wire logic                   pop,
    output fpd_pkg::queue_word_t        head_word,
    output fpd_pkg::queue_status_t      qstat
);
    import fpd_pkg::*;

    queue_word_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word   = mem_reg[rd_ptr_reg];
    assign qstat.valid = (count_reg != '0);
    assign qstat.count = count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fpd_back.sv
// back end: flight phase state machine and result register
`timescale 1ns / 1ps
`default_nettype none

module fpd_back
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fpd_pkg::cfg_t          cfg,
    input  wire fpd_pkg::queue_word_t   head_word,
    input  wire fpd_pkg::queue_status_t qstat,
    output logic                        pop,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output fpd_pkg::result_t            result
);
    import fpd_pkg::*;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic signed [ALTITUDE_BITS-1:0] ground_reg;
    logic signed [ALTITUDE_BITS-1:0] ground_next;
    logic                            ground_valid_reg;
    logic                            ground_valid_next;
    logic signed [ALTITUDE_BITS-1:0] prev_reg;
    logic signed [ALTITUDE_BITS-1:0] prev_next;
    logic                            prev_valid_reg;
    logic                            prev_valid_next;
    logic [TIME_BITS-1:0]            since_reg;
    logic [TIME_BITS-1:0]            since_next;
    logic                            running_reg;
    logic                            running_next;
    logic                            landing;
    logic                            out_valid_reg;
    result_t                         out_reg;
    result_t                         out_next;

    logic signed [DIFF_BITS-1:0] rise;
    logic signed [DIFF_BITS-1:0] drop;
    logic signed [DIFF_BITS-1:0] delta;
    logic signed [DIFF_BITS-1:0] delta_abs;
    logic [TIME_BITS-1:0]        held;
    logic                        launch_alt;
    logic                        descend;
    logic                        stable;
    logic                        hold_done;

    assign pop = qstat.valid && (!out_valid_reg || !result_stall);

    assign rise  = DIFF_BITS'(head_word.altitude_cm) - DIFF_BITS'(ground_reg);
    assign drop  = DIFF_BITS'(prev_reg) - DIFF_BITS'(head_word.altitude_cm);
    assign delta = DIFF_BITS'(head_word.altitude_cm) - DIFF_BITS'(prev_reg);
    assign delta_abs = delta[DIFF_BITS-1] ? -delta : delta;
    assign held  = head_word.time_ms - since_reg;

    assign launch_alt = rise > signed'(DIFF_BITS'(cfg.launch_rise_cm));
    assign descend    = drop > signed'(DIFF_BITS'(cfg.descent_drop_cm));
    assign stable     = delta_abs < signed'(DIFF_BITS'(cfg.stable_band_cm));
    assign hold_done  = held >= TIME_BITS'(cfg.landing_hold_ms);

    always_comb
    begin
        phase_next        = phase_reg;
        ground_next       = ground_reg;
        ground_valid_next = ground_valid_reg;
        prev_next         = prev_reg;
        prev_valid_next   = prev_valid_reg;
        since_next        = since_reg;
        running_next      = running_reg;
        landing           = 1'b0;
        case (phase_reg)
            PH_PRE:
            begin
                if (!ground_valid_reg)
                begin
                    ground_next       = head_word.altitude_cm;
                    ground_valid_next = 1'b1;
                end
                else if (launch_alt || head_word.accel_launch)
                begin
                    phase_next = PH_ASC;
                end
            end
            PH_ASC:
            begin
                if (prev_valid_reg && descend)
                begin
                    phase_next = PH_DES;
                end
                prev_next       = head_word.altitude_cm;
                prev_valid_next = 1'b1;
            end
            PH_DES:
            begin
                prev_next       = head_word.altitude_cm;
                prev_valid_next = 1'b1;
                if (prev_valid_reg)
                begin
                    if (stable)
                    begin
                        if (!running_reg)
                        begin
                            running_next = 1'b1;
                            since_next   = head_word.time_ms;
                        end
                        else if (hold_done)
                        begin
                            phase_next = PH_LAND;
                            landing    = 1'b1;
                        end
                    end
                    else
                    begin
                        running_next = 1'b0;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        out_next.flight_state  = phase_next;
        out_next.state_changed = (phase_next != phase_reg);
        out_next.landing_event = landing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_PRE;
            ground_reg       <= '0;
            ground_valid_reg <= 1'b0;
            prev_reg         <= '0;
            prev_valid_reg   <= 1'b0;
            since_reg        <= '0;
            running_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg        <= phase_next;
                ground_reg       <= ground_next;
                ground_valid_reg <= ground_valid_next;
                prev_reg         <= prev_next;
                prev_valid_reg   <= prev_valid_next;
                since_reg        <= since_next;
                running_reg      <= running_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/flight_phase_detector_top.sv
// top level of the flight phase detector: register port, front end, queue, back end
//
// channel   direction  handshake                     word
// sample    in         sample_valid / sample_stall   fpd_pkg::sample_t
// result    out        result_valid / result_stall   fpd_pkg::result_t
// config    in         psel / penable / pready       32 bit apb registers
//
// one sample per cycle sustained while sample_stall is low; a taken sample passes
// the squares register (written on the taking edge), then the magnitude compare
// stage, the queue write and the phase register. the 4-word queue absorbs result
// stalls: sample_stall rises once queued plus in-flight words reach its depth.
// reset returns the phase to prelaunch and the registers to their defaults at once.
`timescale 1ns / 1ps
`default_nettype none

module flight_phase_detector_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fpd_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [fpd_pkg::DATA_BITS-1:0]   pwdata,
    output logic [fpd_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready,
    input  wire logic                            sample_valid,
    output logic                                 sample_stall,
    input  wire fpd_pkg::sample_t                sample,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output fpd_pkg::result_t                     result
);
    import fpd_pkg::*;

    cfg_t          cfg_reg;
    reg_index_t    reg_sel;
    logic          wr_en;
    logic          push;
    logic          pop;
    queue_word_t   push_word;
    queue_word_t   head_word;
    queue_status_t qstat;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launch_rise_cm  <= RISE_RESET;
            cfg_reg.accel_excess_mg <= EXCESS_RESET;
            cfg_reg.descent_drop_cm <= DROP_RESET;
            cfg_reg.stable_band_cm  <= BAND_RESET;
            cfg_reg.landing_hold_ms <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_LAUNCH_RISE:  cfg_reg.launch_rise_cm  <= pwdata[RISE_BITS-1:0];
                REG_ACCEL_EXCESS: cfg_reg.accel_excess_mg <= pwdata[EXCESS_BITS-1:0];
                REG_DESCENT_DROP: cfg_reg.descent_drop_cm <= pwdata[DROP_BITS-1:0];
                REG_STABLE_BAND:  cfg_reg.stable_band_cm  <= pwdata[BAND_BITS-1:0];
                REG_LANDING_HOLD: cfg_reg.landing_hold_ms <= pwdata[HOLD_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LAUNCH_RISE:  prdata = DATA_BITS'(cfg_reg.launch_rise_cm);
            REG_ACCEL_EXCESS: prdata = DATA_BITS'(cfg_reg.accel_excess_mg);
            REG_DESCENT_DROP: prdata = DATA_BITS'(cfg_reg.descent_drop_cm);
            REG_STABLE_BAND:  prdata = DATA_BITS'(cfg_reg.stable_band_cm);
            REG_LANDING_HOLD: prdata = DATA_BITS'(cfg_reg.landing_hold_ms);
            default:          prdata = '0;
        endcase
    end

    fpd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .qstat        (qstat),
        .push         (push),
        .push_word    (push_word)
    );

    fpd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .qstat     (qstat)
    );

    fpd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_word    (head_word),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_flight_phase_detector_top.sv
// self-checking testbench of the flight phase detector: one flight from ground to landed with apb setup
`timescale 1ns / 1ps

module tb_flight_phase_detector_top;

    import fpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [2:0]  REG_UNMAPPED = 3'd7;
    localparam longint      ALT_MAX      = (longint'(1) <<< (ALTITUDE_BITS - 1)) - 1;
    localparam longint      ALT_MIN      = -ALT_MAX - 1;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_BITS-1:0] paddr        = '0;
    logic [DATA_BITS-1:0] pwdata       = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample       = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;

    flight_phase_detector_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    sample_t     pending_samples[$];
    result_t     predicted_phases[$];
    int unsigned queued_count  = 0;
    int unsigned taken_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    int unsigned drv_calm      = 0;
    int unsigned stall_left    = 0;
    int unsigned mon_calm      = 0;
    longint      last_fed_alt  = 0;
    logic [31:0] clock_ms      = '0;

    // mirror of the registers and of the tracker state
    cfg_t        cfg_mirror    = '{RISE_RESET, EXCESS_RESET, DROP_RESET, BAND_RESET, HOLD_RESET};
    phase_t      flight_ph     = PH_PRE;
    longint      ground_alt    = 0;
    logic        ground_seen   = 1'b0;
    longint      last_alt      = 0;
    logic        last_seen     = 1'b0;
    logic [31:0] steady_since  = '0;
    logic        steady_on     = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("error at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int rand_accel();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int rand_signed(input int unsigned span);
        return int'($urandom_range(2 * span)) - int'(span);
    endfunction

    task automatic track_phase(input sample_t s);
        longint      alt;
        longint      ax;
        longint      ay;
        longint      az;
        longint      mag2;
        longint      lim;
        longint      change;
        logic [31:0] held;
        phase_t      was;
        result_t     r;
        alt = $signed(s.altitude_cm);
        ax = $signed(s.accel_x_mg);
        ay = $signed(s.accel_y_mg);
        az = $signed(s.accel_z_mg);
        was = flight_ph;
        r = '0;
        case (flight_ph)
            PH_PRE:
            begin
                if (!ground_seen)
                begin
                    ground_alt = alt;
                    ground_seen = 1'b1;
                end
                else
                begin
                    mag2 = ax * ax + ay * ay + az * az;
                    lim = ONE_G_MG + longint'(cfg_mirror.accel_excess_mg);
                    if (alt - ground_alt > longint'(cfg_mirror.launch_rise_cm) || mag2 > lim * lim)
                        flight_ph = PH_ASC;
                end
            end
            PH_ASC:
            begin
                if (last_seen && last_alt - alt > longint'(cfg_mirror.descent_drop_cm))
                    flight_ph = PH_DES;
                last_alt = alt;
                last_seen = 1'b1;
            end
            PH_DES:
            begin
                if (!last_seen)
                begin
                    last_alt = alt;
                    last_seen = 1'b1;
                end
                else
                begin
                    change = alt - last_alt;
                    if (change < 0)
                        change = -change;
                    last_alt = alt;
                    if (change < longint'(cfg_mirror.stable_band_cm))
                    begin
                        if (!steady_on)
                        begin
                            steady_on = 1'b1;
                            steady_since = s.time_ms;
                        end
                        else
                        begin
                            held = s.time_ms - steady_since;
                            if (held >= 32'(cfg_mirror.landing_hold_ms))
                            begin
                                flight_ph = PH_LAND;
                                r.landing_event = 1'b1;
                            end
                        end
                    end
                    else
                        steady_on = 1'b0;
                end
            end
            default: ;
        endcase
        r.flight_state = flight_ph;
        r.state_changed = (flight_ph != was);
        predicted_phases.push_back(r);
    endtask

    task automatic queue_sample(input longint alt, input int ax, input int ay, input int az,
                                input logic [31:0] stamp);
        sample_t s;
        if (alt > ALT_MAX)
            alt = ALT_MAX;
        if (alt < ALT_MIN)
            alt = ALT_MIN;
        s.altitude_cm = ALTITUDE_BITS'(alt);
        s.accel_x_mg = ACCEL_BITS'(ax);
        s.accel_y_mg = ACCEL_BITS'(ay);
        s.accel_z_mg = ACCEL_BITS'(az);
        s.time_ms = stamp;
        pending_samples.push_back(s);
        queued_count++;
        last_fed_alt = alt;
    endtask

    // upper data bits are random, the register keeps only its own width
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] word;
        word = $urandom();
        case (idx)
            REG_LAUNCH_RISE:
            begin
                word[RISE_BITS-1:0] = value[RISE_BITS-1:0];
                cfg_mirror.launch_rise_cm = value[RISE_BITS-1:0];
            end
            REG_ACCEL_EXCESS:
            begin
                word[EXCESS_BITS-1:0] = value[EXCESS_BITS-1:0];
                cfg_mirror.accel_excess_mg = value[EXCESS_BITS-1:0];
            end
            REG_DESCENT_DROP:
            begin
                word[DROP_BITS-1:0] = value[DROP_BITS-1:0];
                cfg_mirror.descent_drop_cm = value[DROP_BITS-1:0];
            end
            REG_STABLE_BAND:
            begin
                word[BAND_BITS-1:0] = value[BAND_BITS-1:0];
                cfg_mirror.stable_band_cm = value[BAND_BITS-1:0];
            end
            REG_LANDING_HOLD:
            begin
                word[HOLD_BITS-1:0] = value[HOLD_BITS-1:0];
                cfg_mirror.landing_hold_ms = value[HOLD_BITS-1:0];
            end
            default: ;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_results();
        while (taken_count != queued_count || predicted_phases.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample <= '0;
            send_gap = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                track_phase(sample);
                taken_count++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    if (drv_calm != 0)
                    begin
                        drv_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = pick_idle();
                        if ($urandom_range(19) == 0)
                            drv_calm = $urandom_range(80, 20);
                    end
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_phases.size() == 0)
                    report_error($sformatf("word with no prediction, state %0d", result.flight_state));
                else
                begin
                    want = predicted_phases.pop_front();
                    if (result.flight_state !== want.flight_state)
                        report_error($sformatf("flight_state %0d, expected %0d",
                                               result.flight_state, want.flight_state));
                    if (result.state_changed !== want.state_changed)
                        report_error($sformatf("state_changed %0b, expected %0b",
                                               result.state_changed, want.state_changed));
                    if (result.landing_event !== want.landing_event)
                        report_error($sformatf("landing_event %0b, expected %0b",
                                               result.landing_event, want.landing_event));
                end
                results_seen++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (mon_calm != 0)
                    mon_calm--;
                else
                begin
                    stall_left = pick_idle();
                    if ($urandom_range(19) == 0)
                        mon_calm = $urandom_range(80, 20);
                end
            end
        end
    end

    initial
    begin
        longint      ground;
        longint      step;
        logic [31:0] t0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // prelaunch at reset settings; the first word only sets the ground
        ground = longint'($urandom_range(20000)) - 10000;
        queue_sample(ground, -32768, 32767, -32768, $urandom());
        queue_sample(ground + 1000, 0, 0, 0, $urandom());
        queue_sample(ground + 999, 1500, 0, 0, $urandom());
        queue_sample(ground - 5000, 0, -1500, 0, $urandom());
        queue_sample(ground, 0, 0, -1500, $urandom());
        drain_results();

        write_reg(REG_LAUNCH_RISE, 0);
        write_reg(REG_ACCEL_EXCESS, 0);
        queue_sample(ground, 1000, 0, 0, $urandom());
        queue_sample(ground, 0, -600, -800, $urandom());
        queue_sample(ground - 1, 0, 0, 1000, $urandom());
        drain_results();

        write_reg(REG_LAUNCH_RISE, 100000);
        write_reg(REG_ACCEL_EXCESS, 16000);
        write_reg(REG_UNMAPPED, $urandom());
        queue_sample(ground + 100000, 0, 17000, 0, $urandom());
        for (int i = 0; i < 150; i++)
            queue_sample(ground + rand_signed(100000), rand_signed(9000), rand_signed(9000),
                         rand_signed(9000), $urandom());

        // launch by rise or by acceleration
        if ($urandom_range(1) == 0)
            queue_sample(ground + 100001, rand_signed(9000), rand_signed(9000),
                         rand_signed(9000), $urandom());
        else
            queue_sample(ground, ($urandom_range(1) == 0) ? 17001 : -17001, 0, 0, $urandom());

        // first ascent word only records the altitude
        clock_ms = $urandom();
        queue_sample(ground - 500000, rand_accel(), rand_accel(), rand_accel(), clock_ms);
        queue_sample(last_fed_alt - 100, rand_accel(), rand_accel(), rand_accel(), clock_ms + 10);
        drain_results();

        write_reg(REG_DESCENT_DROP, 100000);
        for (int i = 0; i < 120; i++)
        begin
            step = longint'($urandom_range(300000)) - 100000;
            clock_ms += $urandom_range(200, 1);
            queue_sample(last_fed_alt + step, rand_accel(), rand_accel(), rand_accel(), clock_ms);
        end
        queue_sample(ALT_MAX, rand_accel(), rand_accel(), rand_accel(), clock_ms + 1);
        queue_sample(ALT_MAX - 100000, rand_accel(), rand_accel(), rand_accel(), clock_ms + 2);
        drain_results();

        write_reg(REG_DESCENT_DROP, 0);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), clock_ms + 3);
        queue_sample(last_fed_alt - 1, rand_accel(), rand_accel(), rand_accel(), clock_ms + 4);

        // descent at reset band and hold, hold timer across the time wrap
        t0 = $urandom();
        queue_sample(last_fed_alt - 199, rand_accel(), rand_accel(), rand_accel(), t0);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), t0 + 2999);
        queue_sample(last_fed_alt - 200, rand_accel(), rand_accel(), rand_accel(), t0 + 3100);
        queue_sample(ALT_MIN, rand_accel(), rand_accel(), rand_accel(), t0 + 3200);
        t0 = 32'hFFFF_FF00;
        queue_sample(ALT_MIN + 50, rand_accel(), rand_accel(), rand_accel(), t0);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), t0 + 2999);
        drain_results();

        write_reg(REG_STABLE_BAND, 0);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), t0 + 4000);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), t0 + 9000);
        drain_results();

        write_reg(REG_STABLE_BAND, 100000);
        write_reg(REG_LANDING_HOLD, 600000);
        clock_ms = t0 + 9000;
        for (int i = 0; i < 180; i++)
        begin
            if (i == 90)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
            else
                clock_ms += $urandom_range(5000, 1);
            if ($urandom_range(9) < 7)
                step = rand_signed(99999);
            else if ($urandom_range(1) == 0)
                step = $urandom_range(300000, 100000);
            else
                step = -longint'($urandom_range(300000, 100000));
            queue_sample(last_fed_alt + step, rand_accel(), rand_accel(), rand_accel(), clock_ms);
        end
        drain_results();

        // zero hold: the word that starts the timer never lands, the next one does
        write_reg(REG_LANDING_HOLD, 0);
        clock_ms += 100;
        queue_sample(last_fed_alt > 0 ? last_fed_alt - 200000 : last_fed_alt + 200000,
                     rand_accel(), rand_accel(), rand_accel(), clock_ms);
        queue_sample(last_fed_alt, rand_accel(), rand_accel(), rand_accel(), clock_ms + 1);
        queue_sample(last_fed_alt + 10, rand_accel(), rand_accel(), rand_accel(), clock_ms + 1);

        // landed is terminal
        for (int i = 0; i < 75; i++)
            queue_sample(longint'($urandom_range(24'hFF_FFFF)) + ALT_MIN, rand_accel(), rand_accel(),
                         rand_accel(), $urandom());
        drain_results();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
